### design/c3zp_pkg.sv
// Shared types, constants and helpers for the 3x3 zero-padded convolution filter.
// Used by c3zp_line_buf, c3zp_kernel_mac and the top level; depends on nothing.
`default_nettype none

package c3zp_pkg;

    // Line geometry
    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = COL_W + 1;
    localparam int ROW_W     = 16;
    localparam int IMG_W_W   = 13;

    // Pixel and coefficient formats
    localparam int PIX_W   = 8;
    localparam int COEF_W  = 16;
    localparam int FRAC_W  = 12;
    localparam int KROW_W  = 3 * COEF_W;
    localparam int NTAPS   = 9;
    localparam int PROD_W  = PIX_W + 1 + COEF_W;
    localparam int SUM_W   = PROD_W + 4;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = KROW_W;

    // Result queue and pipeline depth
    localparam int PIPE_DEPTH = 5;
    localparam int INFL_W     = $clog2(PIPE_DEPTH + 1);
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Rounding and saturation
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 << (FRAC_W - 1));
    localparam logic signed [SUM_W-1:0] SAT_LIMIT  = SUM_W'(255 * (1 << FRAC_W));
    localparam logic [PIX_W-1:0]        PIX_MAX    = PIX_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH       = 3'd0,
        CFG_IMAGE_HEIGHT      = 3'd1,
        CFG_KERNEL_ROW_TOP    = 3'd2,
        CFG_KERNEL_ROW_MIDDLE = 3'd3,
        CFG_KERNEL_ROW_BOTTOM = 3'd4,
        CFG_WINDOW_RADIUS     = 3'd5
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

    // Window taps, index row*3+column, row 0 on top, column 0 on the left
    typedef pix_t [NTAPS-1:0] tap_vec_t;

    // Per-request control that travels with the window
    typedef struct packed {
        logic             primed;
        logic             last;
        logic [NTAPS-1:0] tap_en;
    } ctl_t;

    // Clamp to 0..255 and round half up from Q.12
    function automatic pix_t clamp_round(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        r = s + ROUND_HALF;
        if (s > SAT_LIMIT) begin
            return PIX_MAX;
        end
        else if (s[SUM_W-1]) begin
            return '0;
        end
        else begin
            return r[FRAC_W +: PIX_W];
        end
    endfunction

endpackage

`default_nettype wire

### design/conv3x3_zero_pad_filter_unit.sv
// A result passes the line memory read, the window taps and the product, row-sum and result
// registers, enters the queue and shows on out_valid in the following cycle; the first width+1
// requests of a frame yield nothing. Throughput: one request per clock while in_stall is low,
// set by the line memory doing one read and one write-back per request with single-entry
// forwarding. Reset (rst_n, async, active low) clears the counters, the window taps, the queue
// and loads the default registers; the line memory is not cleared and needs no clearing pass.
`default_nettype none

module conv3x3_zero_pad_filter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               func,
    input  logic [c3zp_pkg::PIX_W-1:0]         pixel_in,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [c3zp_pkg::PIX_W-1:0]         pixel_out,
    output logic                               frame_end,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [c3zp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [c3zp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import c3zp_pkg::*;

    localparam logic [ROW_W-1:0] ROW_MAX = '1;

    logic [IMG_W_W-1:0] image_width_reg;
    logic [ROW_W-1:0]   image_height_reg;
    logic [KROW_W-1:0]  krow_top_reg;
    logic [KROW_W-1:0]  krow_mid_reg;
    logic [KROW_W-1:0]  krow_bot_reg;
    logic               radius_reg;

    logic [COL_W-1:0]   in_col_reg;
    logic [ROW_W-1:0]   in_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [ROW_W-1:0]   out_row_reg;

    logic [WID_W-1:0]   w_eff;
    logic [ROW_W-1:0]   h_eff;
    logic [WID_W-1:0]   col_plus;
    logic [WID_W-1:0]   x_plus;
    logic [ROW_W:0]     y_plus;
    logic               accept;
    logic               top_ok;
    logic               bot_ok;
    logic               left_ok;
    logic               right_ok;
    logic [2:0]         row_ok;
    logic [2:0]         col_ok;
    ctl_t               ctl_now;
    pix_t               pix_now;

    logic               v1_reg;
    logic               v2_reg;
    ctl_t               ctl1_reg;
    ctl_t               ctl2_reg;
    tap_vec_t           taps;

    logic               res_valid;
    pix_t               res_pixel;
    logic               res_last;

    logic [INFL_W-1:0]  inflight_reg;
    pix_t               q_pix [QDEPTH];
    logic               q_last [QDEPTH];
    logic [QPTR_W-1:0]  q_head_reg;
    logic [QPTR_W-1:0]  q_tail_reg;
    logic [QCNT_W-1:0]  q_count_reg;
    logic               q_pop;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            image_width_reg  <= IMG_W_W'(640);
            image_height_reg <= ROW_W'(480);
            krow_top_reg     <= '0;
            krow_mid_reg     <= KROW_W'(48'h0000_1000_0000);
            krow_bot_reg     <= '0;
            radius_reg       <= 1'b1;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:       image_width_reg  <= cfg_data[IMG_W_W-1:0];
                CFG_IMAGE_HEIGHT:      image_height_reg <= cfg_data[ROW_W-1:0];
                CFG_KERNEL_ROW_TOP:    krow_top_reg     <= cfg_data[KROW_W-1:0];
                CFG_KERNEL_ROW_MIDDLE: krow_mid_reg     <= cfg_data[KROW_W-1:0];
                CFG_KERNEL_ROW_BOTTOM: krow_bot_reg     <= cfg_data[KROW_W-1:0];
                CFG_WINDOW_RADIUS:     radius_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Effective geometry
    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WID_W'(1);
        end
        else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end
        else begin
            w_eff = WID_W'(image_width_reg);
        end
    end

    assign h_eff = (image_height_reg == '0) ? ROW_W'(1) : image_height_reg;

    // Classify the request against the frame edges
    assign accept   = in_valid && !in_stall;
    assign pix_now  = func ? '0 : pixel_in;
    assign col_plus = {1'b0, in_col_reg} + WID_W'(1);
    assign x_plus   = {1'b0, out_col_reg} + WID_W'(1);
    assign y_plus   = {1'b0, out_row_reg} + (ROW_W+1)'(1);
    assign top_ok   = out_row_reg != '0;
    assign bot_ok   = y_plus < {1'b0, h_eff};
    assign left_ok  = out_col_reg != '0;
    assign right_ok = x_plus < w_eff;
    assign row_ok   = {bot_ok, 1'b1, top_ok};
    assign col_ok   = {right_ok, 1'b1, left_ok};

    always_comb begin
        ctl_now.primed = (in_row_reg >= ROW_W'(2))
                      || ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        ctl_now.last   = !right_ok && !bot_ok;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (radius_reg) begin
                    ctl_now.tap_en[r*3+c] = row_ok[r] && col_ok[c];
                end
                else begin
                    ctl_now.tap_en[r*3+c] = (r == 1) && (c == 1);
                end
            end
        end
    end

    // Advance the input and output positions
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept) begin
            if (ctl_now.primed && ctl_now.last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else begin
                if (col_plus >= w_eff) begin
                    in_col_reg <= '0;
                    if (in_row_reg != ROW_MAX) begin
                        in_row_reg <= in_row_reg + ROW_W'(1);
                    end
                end
                else begin
                    in_col_reg <= col_plus[COL_W-1:0];
                end
                if (ctl_now.primed) begin
                    if (!right_ok) begin
                        out_col_reg <= '0;
                        out_row_reg <= y_plus[ROW_W-1:0];
                    end
                    else begin
                        out_col_reg <= x_plus[COL_W-1:0];
                    end
                end
            end
        end
    end

    // Line memory and window
    c3zp_line_buf u_line_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .idx   (in_col_reg),
        .pix   (pix_now),
        .taps  (taps)
    );

    // Keep control in step with the memory stage and the window shift
    always_ff @(posedge clk) begin
        if (accept) begin
            ctl1_reg <= ctl_now;
        end
        ctl2_reg <= ctl1_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    // Filter arithmetic
    c3zp_kernel_mac u_kernel_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (v2_reg),
        .ctl       (ctl2_reg),
        .taps      (taps),
        .krow_top  (krow_top_reg),
        .krow_mid  (krow_mid_reg),
        .krow_bot  (krow_bot_reg),
        .radius    (radius_reg),
        .res_valid (res_valid),
        .res_pixel (res_pixel),
        .res_last  (res_last)
    );

    // Count results still in the pipeline so the queue never overflows
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            inflight_reg <= '0;
        end
        else begin
            case ({accept && ctl_now.primed, res_valid})
                2'b10:   inflight_reg <= inflight_reg + INFL_W'(1);
                2'b01:   inflight_reg <= inflight_reg - INFL_W'(1);
                default: inflight_reg <= inflight_reg;
            endcase
        end
    end

    assign in_stall = ({1'b0, q_count_reg} + (QCNT_W+1)'(inflight_reg))
                      >= (QCNT_W+1)'(QDEPTH);

    // Output queue
    assign q_pop     = out_valid && !out_stall;
    assign out_valid = q_count_reg != '0;
    assign pixel_out = q_pix[q_head_reg];
    assign frame_end = q_last[q_head_reg];

    always_ff @(posedge clk) begin
        if (res_valid) begin
            q_pix[q_tail_reg]  <= res_pixel;
            q_last[q_tail_reg] <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            q_head_reg  <= '0;
            q_tail_reg  <= '0;
            q_count_reg <= '0;
        end
        else begin
            if (res_valid) begin
                q_tail_reg <= q_tail_reg + QPTR_W'(1);
            end
            if (q_pop) begin
                q_head_reg <= q_head_reg + QPTR_W'(1);
            end
            case ({res_valid, q_pop})
                2'b10:   q_count_reg <= q_count_reg + QCNT_W'(1);
                2'b01:   q_count_reg <= q_count_reg - QCNT_W'(1);
                default: q_count_reg <= q_count_reg;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (q_count_reg < QCNT_W'(QDEPTH)) || q_pop)
        else $error("result queue overflow");

    a_result_was_counted: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (inflight_reg != '0))
        else $error("result without a counted request");

    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= INFL_W'(PIPE_DEPTH))
        else $error("more results in flight than pipeline stages");

    a_frame_end_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ctl_now.primed && ctl_now.last |=>
            (in_col_reg == '0) && (in_row_reg == '0)
            && (out_col_reg == '0) && (out_row_reg == '0))
        else $error("positions not cleared after frame end");
`endif

endmodule

`default_nettype wire

### design/c3zp_line_buf.sv
// Two-row line memory with read-modify-write per request, and the 3x3 tap window.
// Depends on c3zp_pkg.
`default_nettype none

module c3zp_line_buf (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic [c3zp_pkg::COL_W-1:0]  idx,
    input  c3zp_pkg::pix_t              pix,
    output c3zp_pkg::tap_vec_t          taps
);
    import c3zp_pkg::*;

    // Each word holds {upper row, lower row} of one column
    logic [2*PIX_W-1:0] mem [0:MAX_WIDTH-1];

    logic               s1_valid_reg;
    logic [COL_W-1:0]   s1_idx_reg;
    pix_t               s1_pix_reg;
    logic [2*PIX_W-1:0] rd_data_reg;
    logic               fwd_hit_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] s1_word;
    pix_t               s1_top;
    pix_t               s1_mid;
    tap_vec_t           tap_reg;

    // Take the write that lands on the same edge as the read when addresses match
    assign s1_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign s1_top  = s1_word[2*PIX_W-1:PIX_W];
    assign s1_mid  = s1_word[PIX_W-1:0];

    // Read on accept, write back the shifted column in the next cycle
    always_ff @(posedge clk) begin
        if (push) begin
            rd_data_reg <= mem[idx];
        end
        if (s1_valid_reg) begin
            mem[s1_idx_reg] <= {s1_mid, s1_pix_reg};
        end
    end

    // Hold request payload and forwarding data
    always_ff @(posedge clk) begin
        if (push) begin
            s1_idx_reg   <= idx;
            s1_pix_reg   <= pix;
            fwd_data_reg <= {s1_mid, s1_pix_reg};
        end
    end

    // Track the stage and the read-during-write hazard
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else begin
            s1_valid_reg <= push;
            if (push) begin
                fwd_hit_reg <= s1_valid_reg && (s1_idx_reg == idx);
            end
        end
    end

    // Shift the window left and load the new column on the right
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            tap_reg <= '0;
        end
        else if (s1_valid_reg) begin
            for (int r = 0; r < 3; r++) begin
                tap_reg[r*3+0] <= tap_reg[r*3+1];
                tap_reg[r*3+1] <= tap_reg[r*3+2];
            end
            tap_reg[2] <= s1_top;
            tap_reg[5] <= s1_mid;
            tap_reg[8] <= s1_pix_reg;
        end
    end

    assign taps = tap_reg;

endmodule

`default_nettype wire

### design/c3zp_kernel_mac.sv
// Nine-tap multiply, row sums, total with clamp and rounding: three register stages.
// Depends on c3zp_pkg.
`default_nettype none

module c3zp_kernel_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid,
    input  c3zp_pkg::ctl_t               ctl,
    input  c3zp_pkg::tap_vec_t           taps,
    input  logic [c3zp_pkg::KROW_W-1:0]  krow_top,
    input  logic [c3zp_pkg::KROW_W-1:0]  krow_mid,
    input  logic [c3zp_pkg::KROW_W-1:0]  krow_bot,
    input  logic                         radius,
    output logic                         res_valid,
    output c3zp_pkg::pix_t               res_pixel,
    output logic                         res_last
);
    import c3zp_pkg::*;

    logic [KROW_W-1:0]        krow [3];
    logic signed [COEF_W-1:0] coef [NTAPS];
    logic signed [PROD_W-1:0] prod_reg [NTAPS];
    logic signed [SUM_W-1:0]  row_sum_reg [3];
    logic signed [SUM_W-1:0]  total;
    logic                     vp_reg;
    logic                     vr_reg;
    logic                     res_valid_reg;
    logic                     lp_reg;
    logic                     lr_reg;
    logic                     res_last_reg;
    pix_t                     res_pixel_reg;

    assign krow[0] = krow_top;
    assign krow[1] = krow_mid;
    assign krow[2] = krow_bot;

    // Pick coefficients; centre-only mode uses the first top coefficient
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef[r*3+c] = krow[r][c*COEF_W +: COEF_W];
            end
        end
        if (!radius) begin
            coef[4] = krow_top[COEF_W-1:0];
        end
    end

    // Multiply each tap, drop taps outside the frame
    always_ff @(posedge clk) begin
        for (int k = 0; k < NTAPS; k++) begin
            if (ctl.tap_en[k]) begin
                prod_reg[k] <= $signed({1'b0, taps[k]}) * coef[k];
            end
            else begin
                prod_reg[k] <= '0;
            end
        end
        lp_reg <= ctl.last;
    end

    // Add each row
    always_ff @(posedge clk) begin
        for (int r = 0; r < 3; r++) begin
            row_sum_reg[r] <= SUM_W'(prod_reg[r*3+0]) + SUM_W'(prod_reg[r*3+1])
                            + SUM_W'(prod_reg[r*3+2]);
        end
        lr_reg <= lp_reg;
    end

    assign total = row_sum_reg[0] + row_sum_reg[1] + row_sum_reg[2];

    // Clamp, round and hold the result
    always_ff @(posedge clk) begin
        res_pixel_reg <= clamp_round(total);
        res_last_reg  <= lr_reg;
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vp_reg        <= 1'b0;
            vr_reg        <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else begin
            vp_reg        <= valid && ctl.primed;
            vr_reg        <= vp_reg;
            res_valid_reg <= vr_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_pixel = res_pixel_reg;
    assign res_last  = res_last_reg;

endmodule

`default_nettype wire
